// ----- hw/rtl/crsq_pkg.sv -----
package crsq_pkg;

    typedef enum logic [1:0]
    {
        OP_ADD  = 2'd0,
        OP_SEND = 2'd1,
        OP_ACK  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed
    {
        logic [1:0]  operation;
        logic [15:0] node_addr;
        logic [7:0]  msg_kind;
        logic [7:0]  reading;
        logic [2:0]  slot_index;
        logic        link_connected;
    } in_item_t;

    typedef struct packed
    {
        logic        send_valid;
        logic [2:0]  send_slot;
        logic [15:0] send_addr;
        logic [7:0]  send_kind;
        logic [7:0]  send_reading;
        logic [2:0]  add_slot;
        logic        add_merged;
        logic        add_evicted;
        logic        ack_matched;
    } out_item_t;

endpackage

// ----- hw/rtl/crsq_front.sv -----
module crsq_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  crsq_pkg::in_item_t  in_item,
    output logic                q_valid,
    input  logic                q_ready,
    output crsq_pkg::in_item_t  q_item
);
    import crsq_pkg::*;

    // two-entry queue between intake and execution
    in_item_t   buf_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = buf_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // payload store
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= in_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- hw/rtl/crsq_back.sv -----
module crsq_back
#(
    parameter int QUEUE_SLOTS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  crsq_pkg::in_item_t  q_item,
    output logic                out_valid,
    input  logic                out_ready,
    output crsq_pkg::out_item_t out_item
);
    import crsq_pkg::*;

    localparam int IW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_OUT
    } state_t;

    state_t          state_reg;
    in_item_t        cur_reg;
    out_item_t       res_reg;
    logic [IW:0]     k_reg;
    logic [IW-1:0]   last_free_reg;
    logic            hit_reg;
    logic [IW-1:0]   hit_slot_reg;
    logic            found_reg;
    logic [IW-1:0]   found_slot_reg;
    logic [IW-1:0]   ins_cur_reg;
    logic [IW-1:0]   snd_cur_reg;
    logic [QUEUE_SLOTS-1:0] full_reg;

    logic [15:0] mem_addr [QUEUE_SLOTS];
    logic [7:0]  mem_kind [QUEUE_SLOTS];
    logic [7:0]  mem_val  [QUEUE_SLOTS];

    logic [IW-1:0] base;
    logic [IW:0]   sum;
    logic [IW-1:0] s_idx;
    logic [IW-1:0] add_tgt;
    logic [IW:0]   add_sum;
    logic          ack_in_range;
    logic [IW-1:0] ack_idx;

    function automatic logic [IW-1:0] wrap(input logic [IW:0] v);
        logic [IW:0] r;
        r = (v >= (IW+1)'(QUEUE_SLOTS)) ? v - (IW+1)'(QUEUE_SLOTS) : v;
        return r[IW-1:0];
    endfunction

    // current scan slot, one per cycle
    assign base    = (op_t'(cur_reg.operation) == OP_ADD) ? ins_cur_reg : snd_cur_reg;
    assign sum     = {1'b0, base} + k_reg;
    assign s_idx   = wrap(sum);
    assign add_sum = {1'b0, ins_cur_reg} + {1'b0, last_free_reg};
    assign add_tgt = hit_reg ? hit_slot_reg : wrap(add_sum);
    assign ack_in_range = ({{(IW+3){1'b0}}, cur_reg.slot_index} < (IW+6)'(QUEUE_SLOTS));
    assign ack_idx = IW'(cur_reg.slot_index);

    assign q_ready   = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_item  = res_reg;

    // slot payload memory
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH && op_t'(cur_reg.operation) == OP_ADD)
        begin
            mem_val[add_tgt] <= cur_reg.reading;
            if (!hit_reg)
            begin
                mem_addr[add_tgt] <= cur_reg.node_addr;
                mem_kind[add_tgt] <= cur_reg.msg_kind;
            end
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            full_reg    <= '0;
            ins_cur_reg <= '0;
            snd_cur_reg <= '0;
            k_reg       <= '0;
            hit_reg     <= 1'b0;
            found_reg   <= 1'b0;
            last_free_reg  <= '0;
            hit_slot_reg   <= '0;
            found_slot_reg <= '0;
            cur_reg     <= '0;
            res_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg       <= q_item;
                        k_reg         <= '0;
                        hit_reg       <= 1'b0;
                        found_reg     <= 1'b0;
                        last_free_reg <= '0;
                        res_reg       <= '0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (op_t'(cur_reg.operation) == OP_ADD
                        || (op_t'(cur_reg.operation) == OP_SEND && cur_reg.link_connected))
                    begin
                        if (op_t'(cur_reg.operation) == OP_ADD)
                        begin
                            if (!full_reg[s_idx])
                            begin
                                last_free_reg <= k_reg[IW-1:0];
                            end
                            else if (mem_addr[s_idx] == cur_reg.node_addr
                                     && mem_kind[s_idx] == cur_reg.msg_kind)
                            begin
                                hit_reg      <= 1'b1;
                                hit_slot_reg <= s_idx;
                                state_reg    <= ST_FINISH;
                            end
                        end
                        else if (full_reg[s_idx])
                        begin
                            found_reg      <= 1'b1;
                            found_slot_reg <= s_idx;
                            state_reg      <= ST_FINISH;
                        end
                        if (k_reg == (IW+1)'(QUEUE_SLOTS - 1))
                        begin
                            state_reg <= ST_FINISH;
                        end
                        k_reg <= k_reg + (IW+1)'(1);
                    end
                    else
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    state_reg <= ST_OUT;
                    case (op_t'(cur_reg.operation))
                        OP_ADD:
                        begin
                            res_reg.add_slot   <= 3'(add_tgt);
                            res_reg.add_merged <= hit_reg;
                            if (!hit_reg)
                            begin
                                res_reg.add_evicted <= full_reg[add_tgt];
                                full_reg[add_tgt]   <= 1'b1;
                                ins_cur_reg <= wrap({1'b0, ins_cur_reg} + (IW+1)'(1));
                            end
                        end
                        OP_SEND:
                        begin
                            if (cur_reg.link_connected)
                            begin
                                if (found_reg)
                                begin
                                    res_reg.send_valid   <= 1'b1;
                                    res_reg.send_slot    <= 3'(found_slot_reg);
                                    res_reg.send_addr    <= mem_addr[found_slot_reg];
                                    res_reg.send_kind    <= mem_kind[found_slot_reg];
                                    res_reg.send_reading <= mem_val[found_slot_reg];
                                    snd_cur_reg <= wrap({1'b0, found_slot_reg} + (IW+1)'(1));
                                end
                                else
                                begin
                                    snd_cur_reg <= wrap({1'b0, snd_cur_reg} + (IW+1)'(1));
                                end
                            end
                        end
                        OP_ACK:
                        begin
                            if (ack_in_range)
                            begin
                                res_reg.ack_matched <= full_reg[ack_idx]
                                    && mem_kind[ack_idx] == cur_reg.msg_kind
                                    && mem_addr[ack_idx] == cur_reg.node_addr;
                                full_reg[ack_idx] <= 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/coalescing_retransmit_slot_queue.sv -----
// channel | direction | handshake            | payload
// input   | in        | in_valid / in_ready  | in_item  (crsq_pkg::in_item_t)
// output  | out       | out_valid / out_ready| out_item (crsq_pkg::out_item_t)
//
// one item at a time in the executor: idle, scan, finish, then output, with
// at least one scan step and at most QUEUE_SLOTS, set by the one-slot-a-cycle scan
// a two-item input queue keeps taking items while a result waits
// reset clears occupancy flags and both cursors at once; slot data is undefined
// a stalled result holds the executor; the input queue fills then stalls
module coalescing_retransmit_slot_queue
#(
    parameter int QUEUE_SLOTS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  crsq_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output crsq_pkg::out_item_t out_item
);
    import crsq_pkg::*;

    logic     q_valid;
    logic     q_ready;
    in_item_t q_item;

    // intake queue
    crsq_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // executor
    crsq_back #(.QUEUE_SLOTS(QUEUE_SLOTS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

`ifndef SYNTHESIS
    // a result never claims both merge and eviction
    a_merge_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.add_merged && out_item.add_evicted))
        else $error("merge and evict together");

    // a send result only carries data when valid
    a_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.send_valid) |-> (out_item.send_addr == 16'd0))
        else $error("send data without send_valid");

    // stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
        else $error("result changed while stalled");
`endif

endmodule
